// File: rtl/trsm_pkg.sv
// Shared types and codes for the TCP receive state machine.
// Used by the top, trsm_cfg, trsm_rules and the checker; no dependencies.
package trsm_pkg;

	localparam int CONNECTIONS_DEF = 16;

	localparam logic OP_SEGMENT = 1'b0;
	localparam logic OP_WRITE   = 1'b1;

	localparam logic [3:0] ST_CLOSED      = 4'd0;
	localparam logic [3:0] ST_LISTEN      = 4'd1;
	localparam logic [3:0] ST_SYN_RECV    = 4'd2;
	localparam logic [3:0] ST_SYN_SENT    = 4'd3;
	localparam logic [3:0] ST_ESTABLISHED = 4'd4;
	localparam logic [3:0] ST_CLOSE_WAIT  = 4'd5;
	localparam logic [3:0] ST_LAST_ACK    = 4'd6;
	localparam logic [3:0] ST_FIN_WAIT_1  = 4'd7;
	localparam logic [3:0] ST_FIN_WAIT_2  = 4'd8;
	localparam logic [3:0] ST_CLOSING     = 4'd9;
	localparam logic [3:0] ST_TIME_WAIT   = 4'd10;

	localparam int FL_FIN = 0;
	localparam int FL_SYN = 1;
	localparam int FL_RST = 2;
	localparam int FL_ACK = 4;

	localparam logic [1:0] RP_NONE   = 2'd0;
	localparam logic [1:0] RP_ACK    = 2'd1;
	localparam logic [1:0] RP_SYNACK = 2'd2;
	localparam logic [1:0] RP_RST    = 2'd3;

	localparam logic [2:0] NT_NONE     = 3'd0;
	localparam logic [2:0] NT_CONNECT  = 3'd1;
	localparam logic [2:0] NT_ACCEPT   = 3'd2;
	localparam logic [2:0] NT_RELEASED = 3'd3;
	localparam logic [2:0] NT_TIMEWAIT = 3'd4;

	localparam logic REG_WINDOW = 1'b0;

	typedef enum logic [1:0] {
		CTL_CLEAR,
		CTL_IDLE,
		CTL_EXEC
	} ctl_state_t;

	typedef struct packed {
		logic [3:0]  state;
		logic [31:0] rcv_next;
		logic [31:0] snd_una;
		logic [3:0]  parent;
	} ctx_t;

	typedef struct packed {
		logic        operation;
		logic [3:0]  conn_slot;
		logic [3:0]  child_slot;
		logic [7:0]  flags;
		logic [31:0] seq;
		logic [31:0] seq_end;
		logic [31:0] ack_number;
		logic [3:0]  new_state;
	} req_t;

	typedef struct packed {
		logic en;
		logic to_child;
		ctx_t ctx;
	} upd_t;

	typedef struct packed {
		logic [1:0]  reply;
		logic        dropped;
		logic [3:0]  state_after;
		logic [2:0]  notify;
		logic [3:0]  parent_out;
		logic [31:0] rcv_next;
		logic [31:0] send_unacked;
	} res_t;

endpackage

// File: rtl/tcp_receive_state_machine.sv
// Top level: TCP receive state machine over a context RAM.
// Depends on trsm_pkg, trsm_ram, trsm_cfg, trsm_rules.
//
// Each accepted word (start high while busy is low) reads its connection
// context from a RAM with registered read data, applies the receive rules
// in the next cycle and writes the context back, so busy is high for one
// cycle and a new word can be taken as soon as busy is low again. The
// result appears on the result ports with done high for exactly one cycle,
// registered from the EXEC state, and is taken at the edge that ends done;
// the receiver must take it then. After reset the context RAM is swept to
// CLOSED and zero, one entry a cycle, so busy stays high until all are cleared
// before the first word is taken; register writes are taken throughout.
module tcp_receive_state_machine #(
	parameter int CONNECTIONS = trsm_pkg::CONNECTIONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [3:0]  conn_slot,
	input  logic [3:0]  child_slot,
	input  logic [7:0]  flags,
	input  logic [31:0] seq,
	input  logic [31:0] seq_end,
	input  logic [31:0] ack_number,
	input  logic [3:0]  new_state,
	output logic        done,
	output logic [1:0]  reply,
	output logic        dropped,
	output logic [3:0]  state_after,
	output logic [2:0]  notify,
	output logic [3:0]  parent_out,
	output logic [31:0] rcv_next,
	output logic [31:0] send_unacked
);

	localparam int AW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
	localparam int CW = $bits(trsm_pkg::ctx_t);

	trsm_pkg::ctl_state_t state_q;
	trsm_pkg::ctl_state_t state_d;
	logic [AW-1:0]        clr_cnt_q;
	logic                 clr_last;
	trsm_pkg::req_t       req_q;
	trsm_pkg::res_t       res_q;
	logic                 done_q;
	logic                 accept;
	logic [15:0]          window;
	logic                 slot_ok;
	logic                 child_ok;
	trsm_pkg::upd_t       upd;
	trsm_pkg::res_t       res;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [CW-1:0]        ram_wdata;
	logic [CW-1:0]        ram_rdata;

	trsm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.window  (window)
	);

	trsm_ram #(
		.WIDTH (CW),
		.DEPTH (CONNECTIONS)
	) u_ctx_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (AW'(conn_slot)),
		.rdata (ram_rdata)
	);

	assign slot_ok  = 32'(req_q.conn_slot) < 32'(CONNECTIONS);
	assign child_ok = 32'(req_q.child_slot) < 32'(CONNECTIONS);

	trsm_rules u_rules (
		.req      (req_q),
		.ctx      (trsm_pkg::ctx_t'(ram_rdata)),
		.window   (window),
		.slot_ok  (slot_ok),
		.child_ok (child_ok),
		.upd      (upd),
		.res      (res)
	);

	assign clr_last = (clr_cnt_q == AW'(CONNECTIONS - 1));
	assign accept   = start && !busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			trsm_pkg::CTL_CLEAR: begin
				if (clr_last) begin
					state_d = trsm_pkg::CTL_IDLE;
				end
			end
			trsm_pkg::CTL_IDLE: begin
				if (start) begin
					state_d = trsm_pkg::CTL_EXEC;
				end
			end
			trsm_pkg::CTL_EXEC: begin
				state_d = trsm_pkg::CTL_IDLE;
			end
			default: begin
				state_d = trsm_pkg::CTL_CLEAR;
			end
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = clr_cnt_q;
		ram_wdata = '0;
		case (state_q)
			trsm_pkg::CTL_CLEAR: begin
				ram_we = 1'b1;
			end
			trsm_pkg::CTL_IDLE: begin
				busy = 1'b0;
			end
			trsm_pkg::CTL_EXEC: begin
				ram_we    = upd.en;
				ram_waddr = upd.to_child ? AW'(req_q.child_slot) : AW'(req_q.conn_slot);
				ram_wdata = upd.ctx;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= trsm_pkg::CTL_CLEAR;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == trsm_pkg::CTL_EXEC);
			if (state_q == trsm_pkg::CTL_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= '{operation: operation, conn_slot: conn_slot,
				child_slot: child_slot, flags: flags, seq: seq,
				seq_end: seq_end, ack_number: ack_number,
				new_state: new_state};
		end
		if (state_q == trsm_pkg::CTL_EXEC) begin
			res_q <= res;
		end
	end

	assign done         = done_q;
	assign reply        = res_q.reply;
	assign dropped      = res_q.dropped;
	assign state_after  = res_q.state_after;
	assign notify       = res_q.notify;
	assign parent_out   = res_q.parent_out;
	assign rcv_next     = res_q.rcv_next;
	assign send_unacked = res_q.send_unacked;

endmodule

// File: rtl/trsm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module trsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/trsm_cfg.sv
// APB register file: receive window register.
// Depends on trsm_pkg.
module trsm_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] window
);

	logic [15:0] window_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == trsm_pkg::REG_WINDOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= 16'hFFFF;
		end else if (wr_en) begin
			window_q <= pwdata[15:0];
		end
	end

	always_comb begin
		if (paddr[2] == trsm_pkg::REG_WINDOW) begin
			prdata = {16'd0, window_q};
		end else begin
			prdata = 32'd0;
		end
	end

	assign window = window_q;

endmodule

// File: rtl/trsm_rules.sv
// Receive rules: next context and result for one segment or local write.
// Depends on trsm_pkg.
module trsm_rules (
	input  trsm_pkg::req_t  req,
	input  trsm_pkg::ctx_t  ctx,
	input  logic [15:0]     window,
	input  logic            slot_ok,
	input  logic            child_ok,
	output trsm_pkg::upd_t  upd,
	output trsm_pkg::res_t  res
);

	logic [31:0] win_w;
	logic [31:0] win_end;
	logic [31:0] diff_hi;
	logic [31:0] diff_lo;
	logic        win_ok;

	assign win_w   = (window == 16'd0) ? 32'd1 : {16'd0, window};
	assign win_end = ctx.rcv_next + win_w;
	assign diff_hi = req.seq - win_end;
	assign diff_lo = ctx.rcv_next - req.seq_end;
	assign win_ok  = diff_hi[31] && (diff_lo[31] || (diff_lo == 32'd0));

	always_comb begin
		trsm_pkg::ctx_t nctx;
		logic [1:0]     reply;
		logic           dropped;
		logic [2:0]     notify;
		logic [3:0]     par;
		logic           to_child;

		nctx     = ctx;
		reply    = trsm_pkg::RP_NONE;
		dropped  = 1'b0;
		notify   = trsm_pkg::NT_NONE;
		par      = 4'd0;
		to_child = 1'b0;

		if (req.operation == trsm_pkg::OP_WRITE) begin
			if (req.new_state <= trsm_pkg::ST_TIME_WAIT) begin
				nctx.state = req.new_state;
			end
		end else if (ctx.state == trsm_pkg::ST_CLOSED
			|| ctx.state > trsm_pkg::ST_TIME_WAIT) begin
			reply = trsm_pkg::RP_RST;
		end else if (ctx.state == trsm_pkg::ST_LISTEN) begin
			if (child_ok) begin
				nctx.state    = trsm_pkg::ST_SYN_RECV;
				nctx.rcv_next = req.seq_end;
				nctx.snd_una  = 32'd0;
				nctx.parent   = req.conn_slot;
				reply         = trsm_pkg::RP_SYNACK;
				to_child      = 1'b1;
			end
		end else if (ctx.state == trsm_pkg::ST_SYN_SENT) begin
			if (req.flags[trsm_pkg::FL_SYN] && req.flags[trsm_pkg::FL_ACK]) begin
				nctx.rcv_next = req.seq_end;
				nctx.snd_una  = req.ack_number;
				nctx.state    = trsm_pkg::ST_ESTABLISHED;
				reply         = trsm_pkg::RP_ACK;
				notify        = trsm_pkg::NT_CONNECT;
			end else begin
				reply = trsm_pkg::RP_RST;
			end
		end else if (!win_ok) begin
			dropped = 1'b1;
		end else if (req.flags[trsm_pkg::FL_RST]) begin
			nctx.state = trsm_pkg::ST_CLOSED;
			notify     = trsm_pkg::NT_RELEASED;
		end else if (req.flags[trsm_pkg::FL_SYN]) begin
			nctx.state = trsm_pkg::ST_CLOSED;
			reply      = trsm_pkg::RP_RST;
			notify     = trsm_pkg::NT_RELEASED;
		end else if (!req.flags[trsm_pkg::FL_ACK]) begin
			dropped = 1'b1;
		end else if (ctx.state == trsm_pkg::ST_SYN_RECV
			|| ctx.state == trsm_pkg::ST_FIN_WAIT_1
			|| ctx.state == trsm_pkg::ST_LAST_ACK) begin
			nctx.rcv_next = req.seq_end;
			nctx.snd_una  = req.ack_number;
			if (ctx.state == trsm_pkg::ST_SYN_RECV) begin
				nctx.state = trsm_pkg::ST_ESTABLISHED;
				notify     = trsm_pkg::NT_ACCEPT;
				par        = ctx.parent;
			end else if (ctx.state == trsm_pkg::ST_FIN_WAIT_1) begin
				nctx.state = trsm_pkg::ST_FIN_WAIT_2;
			end else begin
				nctx.state = trsm_pkg::ST_CLOSED;
				notify     = trsm_pkg::NT_RELEASED;
			end
		end else if (req.flags[trsm_pkg::FL_FIN]) begin
			nctx.rcv_next = req.seq_end;
			nctx.snd_una  = req.ack_number;
			reply         = trsm_pkg::RP_ACK;
			if (ctx.state == trsm_pkg::ST_ESTABLISHED) begin
				nctx.state = trsm_pkg::ST_CLOSE_WAIT;
			end else if (ctx.state == trsm_pkg::ST_FIN_WAIT_2) begin
				nctx.state = trsm_pkg::ST_TIME_WAIT;
				notify     = trsm_pkg::NT_TIMEWAIT;
			end
		end else begin
			reply = trsm_pkg::RP_ACK;
		end

		upd.en       = slot_ok;
		upd.to_child = to_child;
		upd.ctx      = nctx;

		if (slot_ok) begin
			res.reply        = reply;
			res.dropped      = dropped;
			res.state_after  = nctx.state;
			res.notify       = notify;
			res.parent_out   = par;
			res.rcv_next     = nctx.rcv_next;
			res.send_unacked = nctx.snd_una;
		end else begin
			res = '0;
		end
	end

endmodule

// File: rtl/trsm_checker.sv
// Port-level checker for the TCP receive state machine, bound to the top.
// Depends on trsm_pkg and tcp_receive_state_machine.
module trsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  reply,
	input logic        dropped,
	input logic [3:0]  state_after,
	input logic [2:0]  notify
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low right after an accepted word");

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("result missing two cycles after accept");

	a_done_has_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a matching accepted word");

	a_synack_child: assert property (@(posedge clk) disable iff (!arst_n)
		done && reply == trsm_pkg::RP_SYNACK |-> state_after == trsm_pkg::ST_SYN_RECV
			&& !dropped)
		else $error("SYN+ACK reply without SYN_RECV child");

	a_accept_established: assert property (@(posedge clk) disable iff (!arst_n)
		done && notify == trsm_pkg::NT_ACCEPT |-> state_after == trsm_pkg::ST_ESTABLISHED)
		else $error("accept notification in wrong state");

endmodule

bind tcp_receive_state_machine trsm_checker u_trsm_checker (.*);

// File: test/testbench.sv
// Self-checking testbench for tcp_receive_state_machine: directed and random segment
// and state-write words are checked against a shadow copy of the connection table.
// Depends on trsm_pkg and the tcp_receive_state_machine RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int SLOTS = trsm_pkg::CONNECTIONS_DEF;
	localparam logic [2:0] WINDOW_ADDR = {trsm_pkg::REG_WINDOW, 2'b00};
	localparam logic [7:0] FLAG_FIN = 8'(1 << trsm_pkg::FL_FIN);
	localparam logic [7:0] FLAG_SYN = 8'(1 << trsm_pkg::FL_SYN);
	localparam logic [7:0] FLAG_RST = 8'(1 << trsm_pkg::FL_RST);
	localparam logic [7:0] FLAG_ACK = 8'(1 << trsm_pkg::FL_ACK);

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 1'b0;
	logic        busy;
	logic        operation = trsm_pkg::OP_SEGMENT;
	logic [3:0]  conn_slot = '0;
	logic [3:0]  child_slot = '0;
	logic [7:0]  flags = '0;
	logic [31:0] seq = '0;
	logic [31:0] seq_end = '0;
	logic [31:0] ack_number = '0;
	logic [3:0]  new_state = '0;
	logic        done;
	logic [1:0]  reply;
	logic        dropped;
	logic [3:0]  state_after;
	logic [2:0]  notify;
	logic [3:0]  parent_out;
	logic [31:0] rcv_next;
	logic [31:0] send_unacked;

	logic [3:0]  state_of [SLOTS];
	logic [31:0] rcv_next_of [SLOTS];
	logic [31:0] unacked_of [SLOTS];
	logic [3:0]  parent_of [SLOTS];
	logic [15:0] window_now = 16'hFFFF;

	trsm_pkg::res_t expected_results [$];
	int mismatches = 0;
	int results_checked = 0;
	int words_sent = 0;
	int listen_hits = 0;
	int drops = 0;
	int accepts = 0;
	int timewaits = 0;
	int sender_idle_pct = 0;

	tcp_receive_state_machine dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.operation(operation), .conn_slot(conn_slot), .child_slot(child_slot),
		.flags(flags), .seq(seq), .seq_end(seq_end), .ack_number(ack_number),
		.new_state(new_state),
		.done(done), .reply(reply), .dropped(dropped), .state_after(state_after),
		.notify(notify), .parent_out(parent_out), .rcv_next(rcv_next),
		.send_unacked(send_unacked)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit in_window(input logic [31:0] nxt, input logic [31:0] first,
			input logic [31:0] last);
		logic [31:0] span, lim, d_first, d_last;
		span = (window_now == 16'd0) ? 32'd1 : 32'(window_now);
		lim = nxt + span;
		d_first = first - lim;
		d_last = nxt - last;
		return d_first[31] && (d_last[31] || nxt == last);
	endfunction

	function automatic trsm_pkg::res_t predict_word(input trsm_pkg::req_t w);
		trsm_pkg::res_t r;
		logic [3:0] st, shown, slot, child;
		r = '0;
		slot = w.conn_slot;
		child = w.child_slot;
		shown = slot;
		st = state_of[slot];
		words_sent++;
		if (w.operation == trsm_pkg::OP_WRITE) begin
			if (w.new_state <= trsm_pkg::ST_TIME_WAIT)
				state_of[slot] = w.new_state;
		end else if (st == trsm_pkg::ST_CLOSED || st > trsm_pkg::ST_TIME_WAIT) begin
			r.reply = trsm_pkg::RP_RST;
		end else if (st == trsm_pkg::ST_LISTEN) begin
			state_of[child] = trsm_pkg::ST_SYN_RECV;
			rcv_next_of[child] = w.seq_end;
			unacked_of[child] = '0;
			parent_of[child] = slot;
			r.reply = trsm_pkg::RP_SYNACK;
			shown = child;
			listen_hits++;
		end else if (st == trsm_pkg::ST_SYN_SENT) begin
			if (w.flags[trsm_pkg::FL_SYN] && w.flags[trsm_pkg::FL_ACK]) begin
				rcv_next_of[slot] = w.seq_end;
				unacked_of[slot] = w.ack_number;
				state_of[slot] = trsm_pkg::ST_ESTABLISHED;
				r.reply = trsm_pkg::RP_ACK;
				r.notify = trsm_pkg::NT_CONNECT;
			end else begin
				r.reply = trsm_pkg::RP_RST;
			end
		end else if (!in_window(rcv_next_of[slot], w.seq, w.seq_end)) begin
			r.dropped = 1'b1;
		end else if (w.flags[trsm_pkg::FL_RST]) begin
			state_of[slot] = trsm_pkg::ST_CLOSED;
			r.notify = trsm_pkg::NT_RELEASED;
		end else if (w.flags[trsm_pkg::FL_SYN]) begin
			state_of[slot] = trsm_pkg::ST_CLOSED;
			r.reply = trsm_pkg::RP_RST;
			r.notify = trsm_pkg::NT_RELEASED;
		end else if (!w.flags[trsm_pkg::FL_ACK]) begin
			r.dropped = 1'b1;
		end else if (st == trsm_pkg::ST_SYN_RECV || st == trsm_pkg::ST_FIN_WAIT_1
				|| st == trsm_pkg::ST_LAST_ACK) begin
			rcv_next_of[slot] = w.seq_end;
			unacked_of[slot] = w.ack_number;
			if (st == trsm_pkg::ST_SYN_RECV) begin
				state_of[slot] = trsm_pkg::ST_ESTABLISHED;
				r.notify = trsm_pkg::NT_ACCEPT;
				r.parent_out = parent_of[slot];
				accepts++;
			end else if (st == trsm_pkg::ST_FIN_WAIT_1) begin
				state_of[slot] = trsm_pkg::ST_FIN_WAIT_2;
			end else begin
				state_of[slot] = trsm_pkg::ST_CLOSED;
				r.notify = trsm_pkg::NT_RELEASED;
			end
		end else if (w.flags[trsm_pkg::FL_FIN]) begin
			rcv_next_of[slot] = w.seq_end;
			unacked_of[slot] = w.ack_number;
			r.reply = trsm_pkg::RP_ACK;
			if (st == trsm_pkg::ST_ESTABLISHED) begin
				state_of[slot] = trsm_pkg::ST_CLOSE_WAIT;
			end else if (st == trsm_pkg::ST_FIN_WAIT_2) begin
				state_of[slot] = trsm_pkg::ST_TIME_WAIT;
				r.notify = trsm_pkg::NT_TIMEWAIT;
				timewaits++;
			end
		end else begin
			r.reply = trsm_pkg::RP_ACK;
		end
		if (r.dropped)
			drops++;
		r.state_after = state_of[shown];
		r.rcv_next = rcv_next_of[shown];
		r.send_unacked = unacked_of[shown];
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		trsm_pkg::res_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected");
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("reply", 32'(want.reply), 32'(reply));
				check_field("dropped", 32'(want.dropped), 32'(dropped));
				check_field("state_after", 32'(want.state_after), 32'(state_after));
				check_field("notify", 32'(want.notify), 32'(notify));
				check_field("parent_out", 32'(want.parent_out), 32'(parent_out));
				check_field("rcv_next", want.rcv_next, rcv_next);
				check_field("send_unacked", want.send_unacked, send_unacked);
				results_checked++;
			end
		end
	end

	function automatic trsm_pkg::req_t segment_word(input logic [3:0] slot,
			input logic [3:0] child, input logic [7:0] fl, input logic [31:0] first,
			input logic [31:0] last, input logic [31:0] ack);
		trsm_pkg::req_t w;
		w = '0;
		w.operation = trsm_pkg::OP_SEGMENT;
		w.conn_slot = slot;
		w.child_slot = child;
		w.flags = fl;
		w.seq = first;
		w.seq_end = last;
		w.ack_number = ack;
		return w;
	endfunction

	function automatic trsm_pkg::req_t state_write_word(input logic [3:0] slot,
			input logic [3:0] st);
		trsm_pkg::req_t w;
		w = '0;
		w.operation = trsm_pkg::OP_WRITE;
		w.conn_slot = slot;
		w.new_state = st;
		w.seq = $urandom;
		w.ack_number = $urandom;
		return w;
	endfunction

	task automatic send_word(input trsm_pkg::req_t w);
		operation = w.operation;
		conn_slot = w.conn_slot;
		child_slot = w.child_slot;
		flags = w.flags;
		seq = w.seq;
		seq_end = w.seq_end;
		ack_number = w.ack_number;
		new_state = w.new_state;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		expected_results.push_back(predict_word(w));
		@(negedge clk);
		if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 5) - 1) @(negedge clk);
		end
	endtask

	task automatic end_words();
		start = 1'b0;
	endtask

	task automatic wait_idle();
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic read_window();
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b0;
		penable = 1'b0;
		paddr = WINDOW_ADDR;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		check_field("prdata", {16'd0, window_now}, prdata);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic write_window(input logic [15:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = WINDOW_ADDR;
		pwdata = {16'($urandom), value};
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		window_now = value;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		read_window();
	endtask

	task automatic test_window_register();
		read_window();
		write_window(16'h0000);
		write_window(16'h0001);
		write_window(16'hFFFF);
	endtask

	task automatic test_passive_open();
		send_word(segment_word(4'd0, 4'd0, FLAG_SYN, 32'd0, 32'd0, 32'd0));
		send_word(state_write_word(4'd1, trsm_pkg::ST_LISTEN));
		send_word(segment_word(4'd1, 4'd2, FLAG_SYN, 32'd0, 32'hFFFF_FFFF, 32'd0));
		send_word(segment_word(4'd2, 4'd0, FLAG_ACK, rcv_next_of[2], rcv_next_of[2] + 32'd10,
			32'h0000_1234));
		send_word(state_write_word(4'd6, trsm_pkg::ST_LISTEN));
		send_word(segment_word(4'd6, 4'd6, FLAG_SYN, 32'h5555_AAAA, 32'h5555_AAB0, 32'd7));
	endtask

	task automatic test_active_open();
		send_word(state_write_word(4'd3, trsm_pkg::ST_SYN_SENT));
		send_word(segment_word(4'd3, 4'd0, FLAG_ACK, 32'd1, 32'd2, 32'd3));
		send_word(segment_word(4'd3, 4'd0, FLAG_SYN | FLAG_ACK, 32'd0, 32'h8000_0000,
			32'hFFFF_FFFF));
	endtask

	task automatic test_teardown();
		send_word(segment_word(4'd2, 4'd0, FLAG_FIN | FLAG_ACK, rcv_next_of[2],
			rcv_next_of[2] + 32'd1, 32'h0000_2000));
		send_word(segment_word(4'd2, 4'd0, FLAG_ACK, rcv_next_of[2], rcv_next_of[2],
			32'h0000_2001));
		send_word(state_write_word(4'd2, trsm_pkg::ST_LAST_ACK));
		send_word(segment_word(4'd2, 4'd0, FLAG_ACK, rcv_next_of[2], rcv_next_of[2],
			32'h0000_2002));
		send_word(state_write_word(4'd4, trsm_pkg::ST_FIN_WAIT_1));
		send_word(segment_word(4'd4, 4'd0, FLAG_ACK, 32'd0, 32'd0, 32'd100));
		send_word(segment_word(4'd4, 4'd0, FLAG_FIN | FLAG_ACK, 32'd0, 32'd1, 32'd101));
		send_word(state_write_word(4'd5, trsm_pkg::ST_CLOSING));
		send_word(segment_word(4'd5, 4'd0, FLAG_FIN | FLAG_ACK, 32'd0, 32'd100, 32'd55));
	endtask

	task automatic test_drops_and_aborts();
		send_word(segment_word(4'd3, 4'd0, FLAG_ACK, rcv_next_of[3] + 32'd65535,
			rcv_next_of[3] + 32'd65600, 32'd0));
		send_word(segment_word(4'd3, 4'd0, FLAG_FIN, rcv_next_of[3], rcv_next_of[3], 32'd0));
		send_word(segment_word(4'd3, 4'd0, FLAG_RST | FLAG_ACK, rcv_next_of[3],
			rcv_next_of[3], 32'd0));
		send_word(state_write_word(4'd15, trsm_pkg::ST_ESTABLISHED));
		send_word(segment_word(4'd15, 4'd15, FLAG_SYN, 32'd0, 32'd0, 32'd0));
		send_word(state_write_word(4'd7, 4'hF));
		send_word(segment_word(4'd15, 4'd15, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
	endtask

	task automatic make_traffic_word(output trsm_pkg::req_t w);
		logic [3:0] slot;
		logic [31:0] span, base;
		int pick;
		w = '0;
		slot = 4'($urandom);
		w.conn_slot = slot;
		w.child_slot = 4'($urandom);
		w.ack_number = $urandom;
		w.new_state = 4'($urandom);
		w.operation = trsm_pkg::OP_SEGMENT;
		span = (window_now == 16'd0) ? 32'd1 : 32'(window_now);
		base = rcv_next_of[slot];
		if ($urandom_range(0, 99) < 8) begin
			w.operation = 1'($urandom);
			w.flags = 8'($urandom);
			w.seq = $urandom;
			w.seq_end = $urandom;
		end else if ($urandom_range(0, 99) <
				((state_of[slot] == trsm_pkg::ST_CLOSED) ? 60 : 10)) begin
			w.operation = trsm_pkg::OP_WRITE;
			if ($urandom_range(0, 99) < 5)
				w.new_state = 4'($urandom_range(11, 15));
			else
				w.new_state = 4'($urandom_range(0, 10));
		end else begin
			pick = $urandom_range(0, 99);
			if (state_of[slot] == trsm_pkg::ST_SYN_SENT && pick < 60)
				w.flags = FLAG_SYN | FLAG_ACK;
			else if (pick < 40)
				w.flags = FLAG_ACK;
			else if (pick < 60)
				w.flags = FLAG_FIN | FLAG_ACK;
			else if (pick < 68)
				w.flags = FLAG_SYN | FLAG_ACK;
			else if (pick < 74)
				w.flags = FLAG_RST | FLAG_ACK;
			else if (pick < 80)
				w.flags = FLAG_SYN;
			else if (pick < 84)
				w.flags = FLAG_FIN;
			else
				w.flags = 8'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 55)
				w.seq = base + $urandom_range(0, span - 1);
			else if (pick < 65)
				w.seq = base + span - 32'd1;
			else if (pick < 72)
				w.seq = base + span;
			else if (pick < 78)
				w.seq = base - 32'd1;
			else if (pick < 85)
				w.seq = $urandom;
			else
				w.seq = base;
			pick = $urandom_range(0, 99);
			if (pick < 80)
				w.seq_end = w.seq + $urandom_range(0, 1460);
			else if (pick < 90)
				w.seq_end = base - $urandom_range(1, 100);
			else
				w.seq_end = $urandom;
		end
	endtask

	task automatic test_random_traffic(input logic [15:0] window, input int idle_pct,
			input int count);
		trsm_pkg::req_t w;
		int i;
		end_words();
		wait_idle();
		write_window(window);
		sender_idle_pct = idle_pct;
		for (i = 0; i < count; i++) begin
			if (i == count / 2 || $urandom_range(0, 59) == 0) begin
				end_words();
				wait_idle();
			end
			make_traffic_word(w);
			send_word(w);
		end
		end_words();
	endtask

	initial begin : run
		int guard;
		foreach (state_of[i]) begin
			state_of[i] = trsm_pkg::ST_CLOSED;
			rcv_next_of[i] = '0;
			unacked_of[i] = '0;
			parent_of[i] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_window_register();
		test_passive_open();
		test_active_open();
		test_teardown();
		test_drops_and_aborts();
		end_words();
		test_random_traffic(16'h0000, 0, 200);
		test_random_traffic(16'h0001, 46, 200);
		test_random_traffic(16'($urandom_range(2, 65534)), 31, 200);
		test_random_traffic(16'hFFFF, 0, 200);

		guard = 0;
		while (expected_results.size() != 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			mismatches += expected_results.size();
		end
		$display("Covered %0d words and %0d checked results: %0d listen hits, %0d accepts,",
			words_sent, results_checked, listen_hits, accepts);
		$display("%0d drops and %0d time-wait entries, over windows 0, 1, mid and 65535",
			drops, timewaits);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
